// ===== rtl/emdp_pkg.sv =====
package emdp_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int BCNT_W           = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [29:0] ENERGY_DIV   = 30'd3600000;
    localparam logic [15:0] TAG_DATA     = 16'h0010;
    localparam logic [15:0] LEN_END      = 16'hffff;
    localparam logic [7:0]  CHAN_SPECIAL = 8'd144;
    localparam logic [7:0]  TYPE_ENERGY  = 8'd8;
    localparam logic [7:0]  TYPE_POWER   = 8'd4;

    localparam logic [0:0] KIND_MEAS   = 1'b0;
    localparam logic [0:0] KIND_STATUS = 1'b1;

    localparam logic [2:0] Q_ENERGY_IN  = 3'd0;
    localparam logic [2:0] Q_ENERGY_OUT = 3'd1;
    localparam logic [2:0] Q_NET_POWER  = 3'd2;
    localparam logic [2:0] Q_NET_APPAR  = 3'd3;
    localparam logic [2:0] Q_CURRENT    = 3'd4;
    localparam logic [2:0] Q_VOLTAGE    = 3'd5;
    localparam logic [2:0] Q_PF         = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_TERM     = 2'd3;

    localparam logic [0:0] REG_FILTER_EN  = 1'b0;
    localparam logic [0:0] REG_FILTER_VAL = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR, PH_GHDR, PH_GSKIP, PH_DPRE, PH_RHDR, PH_RDATA, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               record_kind;
        logic [2:0]         quantity;
        logic [1:0]         phase;
        logic signed [43:0] value;
        logic [1:0]         packet_status;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
    } res_t;

endpackage

// ===== rtl/emdp_parser.sv =====
module emdp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  emdp_pkg::in_item_t item,
    input  logic               filt_en,
    input  logic [31:0]        filt_val,
    output emdp_pkg::res_t     res
);
    import emdp_pkg::*;

    phase_t             phase_reg, phase_next, cph;
    logic [BCNT_W-1:0]  bc_reg, bc_next;
    logic [15:0]        gr_reg, gr_next, cgr, gr_dec;
    logic [3:0]         fc_reg, fc_next, cfc;
    logic [23:0]        rh_reg, rh_next, crh, rh_sh;
    logic [31:0]        vs_reg, vs_next, cvs, vs_sh;
    logic [7:0]         pl_reg, pl_next, cpl, rlen;
    logic               eg_reg, eg_next, ceg;
    logic [1:0]         drop_reg, drop_next, cdrop;
    logic [21:0]        rem_reg, rem_next;
    logic [43:0]        quo_reg, quo_next;
    logic [31:0]        ia_reg [3];
    logic [31:0]        iap_reg [3];
    logic [31:0]        ia_next [3];
    logic [31:0]        iap_next [3];
    logic               first, take;
    logic [29:0]        dstep;
    logic [7:0]         idx, sub8, b;
    logic [1:0]         ph;
    logic               ph_ok, meas;
    out_item_t          mres, sres;
    logic signed [32:0] net;

    function automatic logic [29:0] div_step(input logic [29:0] x_in);
        logic [29:0] x;
        logic [7:0]  q;
        x = x_in;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            if (x >= (ENERGY_DIV << i)) begin
                x    = x - (ENERGY_DIV << i);
                q[i] = 1'b1;
            end
        end
        return {q, x[21:0]};
    endfunction

    always_comb begin
        first = (bc_reg == '0);
        take  = (bc_reg < BCNT_W'(MAX_PACKET_BYTES));
        b     = item.data_byte;
        cph   = first ? PH_HDR : phase_reg;
        cgr   = first ? '0 : gr_reg;
        cfc   = first ? '0 : fc_reg;
        crh   = first ? '0 : rh_reg;
        cvs   = first ? '0 : vs_reg;
        cpl   = first ? '0 : pl_reg;
        ceg   = first ? 1'b0 : eg_reg;
        cdrop = first ? ST_OK : drop_reg;
        for (int i = 0; i < 3; i++) begin
            ia_next[i]  = first ? '0 : ia_reg[i];
            iap_next[i] = first ? '0 : iap_reg[i];
        end
        gr_dec = (cgr != '0) ? cgr - 16'd1 : cgr;
        vs_sh  = {cvs[23:0], b};
        rh_sh  = {crh[15:0], b};
        dstep  = div_step({rem_reg, b});

        phase_next = cph;
        gr_next    = cgr;
        fc_next    = cfc;
        rh_next    = crh;
        vs_next    = cvs;
        pl_next    = cpl;
        eg_next    = ceg;
        drop_next  = cdrop;
        rem_next   = '0;
        quo_next   = '0;
        meas       = 1'b0;
        mres       = '0;
        rlen       = '0;
        idx        = '0;
        sub8       = '0;
        ph         = '0;
        ph_ok      = 1'b0;
        net        = '0;

        if (take) begin
            unique case (cph)
                PH_HDR: begin
                    if (cfc < 4'd3 && b != (cfc == 4'd0 ? 8'h53 :
                                            cfc == 4'd1 ? 8'h4D : 8'h41)) begin
                        phase_next = PH_DONE;
                        drop_next  = ST_BAD_HDR;
                    end else if (cfc >= 4'd3) begin
                        fc_next    = '0;
                        vs_next    = '0;
                        phase_next = PH_GHDR;
                    end else begin
                        fc_next = cfc + 4'd1;
                    end
                end
                PH_GHDR: begin
                    vs_next = vs_sh;
                    fc_next = cfc + 4'd1;
                    if (cfc + 4'd1 >= 4'd4) begin
                        fc_next = '0;
                        vs_next = '0;
                        gr_next = vs_sh[31:16];
                        if (vs_sh[31:16] == LEN_END) begin
                            phase_next = PH_DONE;
                            drop_next  = ST_TERM;
                        end else if (vs_sh[15:0] == TAG_DATA) begin
                            eg_next    = (vs_sh[31:16] == '0);
                            phase_next = PH_DPRE;
                        end else if (vs_sh[31:16] == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_GSKIP;
                        end
                    end
                end
                PH_GSKIP: begin
                    gr_next = gr_dec;
                    if (gr_dec == '0) phase_next = PH_GHDR;
                end
                PH_DPRE: begin
                    gr_next = gr_dec;
                    vs_next = vs_sh;
                    if (cfc == 4'd7 && filt_en && vs_sh != filt_val) begin
                        phase_next = PH_DONE;
                        drop_next  = ST_MISMATCH;
                    end else begin
                        fc_next = cfc + 4'd1;
                        if (cfc + 4'd1 >= 4'd12) begin
                            if (ceg) begin
                                phase_next = PH_DONE;
                            end else begin
                                fc_next    = '0;
                                vs_next    = '0;
                                phase_next = (gr_dec == '0) ? PH_GHDR : PH_RHDR;
                            end
                        end
                    end
                end
                PH_RHDR: begin
                    gr_next = gr_dec;
                    if (cfc < 4'd3) rh_next = rh_sh;
                    fc_next = cfc + 4'd1;
                    if (cfc + 4'd1 >= 4'd4) begin
                        if (rh_next[7:0] == TYPE_ENERGY || rh_next[7:0] == TYPE_POWER)
                            rlen = rh_next[7:0];
                        else if (rh_next[23:16] == CHAN_SPECIAL)
                            rlen = 8'd4;
                        else
                            rlen = rh_next[7:0];
                        fc_next = '0;
                        vs_next = '0;
                        if (rlen == '0) begin
                            phase_next = (gr_dec == '0) ? PH_GHDR : PH_RHDR;
                        end else begin
                            pl_next    = rlen;
                            phase_next = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    gr_next  = gr_dec;
                    vs_next  = vs_sh;
                    pl_next  = cpl - 8'd1;
                    rem_next = dstep[21:0];
                    quo_next = {quo_reg[35:0], dstep[29:22]};
                    if (cpl == 8'd1) begin
                        // close the record: decode index into phase and sub-code
                        idx   = crh[15:8];
                        ph_ok = (idx >= 8'd20) && (idx < 8'd80);
                        if (idx >= 8'd60) begin
                            ph = 2'd2; sub8 = idx - 8'd60;
                        end else if (idx >= 8'd40) begin
                            ph = 2'd1; sub8 = idx - 8'd40;
                        end else begin
                            ph = 2'd0; sub8 = idx - 8'd20;
                        end
                        mres.record_kind   = KIND_MEAS;
                        mres.phase         = ph;
                        mres.packet_status = ST_OK;
                        if (ph_ok && crh[7:0] == TYPE_ENERGY) begin
                            mres.value = $signed(quo_next);
                            if (sub8 == 8'd1) begin
                                meas = 1'b1; mres.quantity = Q_ENERGY_IN;
                            end else if (sub8 == 8'd2) begin
                                meas = 1'b1; mres.quantity = Q_ENERGY_OUT;
                            end
                        end else if (ph_ok && crh[7:0] == TYPE_POWER) begin
                            case (sub8)
                                8'd1: ia_next[ph] = vs_sh;
                                8'd2: begin
                                    net = $signed({1'b0, ia_next[ph]})
                                        - $signed({1'b0, vs_sh});
                                    meas = 1'b1;
                                    mres.quantity = Q_NET_POWER;
                                    mres.value = 44'(net);
                                end
                                8'd9: iap_next[ph] = vs_sh;
                                8'd10: begin
                                    net = $signed({1'b0, iap_next[ph]})
                                        - $signed({1'b0, vs_sh});
                                    meas = 1'b1;
                                    mres.quantity = Q_NET_APPAR;
                                    mres.value = 44'(net);
                                end
                                8'd11, 8'd12, 8'd13: begin
                                    meas = 1'b1;
                                    mres.quantity = (sub8 == 8'd11) ? Q_CURRENT :
                                                    (sub8 == 8'd12) ? Q_VOLTAGE : Q_PF;
                                    mres.value = $signed({12'd0, vs_sh});
                                end
                                default: ;
                            endcase
                        end
                        fc_next    = '0;
                        vs_next    = '0;
                        phase_next = (gr_dec == '0) ? PH_GHDR : PH_RHDR;
                    end
                end
                default: ;
            endcase
        end

        bc_next = take ? bc_reg + BCNT_W'(1) : bc_reg;
        if (item.last_byte) begin
            if (phase_next == PH_HDR) drop_next = ST_BAD_HDR;
            bc_next    = '0;
            phase_next = PH_HDR;
            fc_next    = '0;
            vs_next    = '0;
        end

        sres               = '0;
        sres.record_kind   = KIND_STATUS;
        sres.packet_status = drop_next;

        res = '0;
        if (meas) begin
            res.r0    = mres;
            res.r1    = sres;
            res.count = item.last_byte ? 2'd2 : 2'd1;
        end else begin
            res.r0    = sres;
            res.count = item.last_byte ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            bc_reg    <= '0;
            gr_reg    <= '0;
            fc_reg    <= '0;
            rh_reg    <= '0;
            vs_reg    <= '0;
            pl_reg    <= '0;
            eg_reg    <= 1'b0;
            drop_reg  <= ST_OK;
            rem_reg   <= '0;
            quo_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                ia_reg[i]  <= '0;
                iap_reg[i] <= '0;
            end
        end else if (fire) begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            gr_reg    <= gr_next;
            fc_reg    <= fc_next;
            rh_reg    <= rh_next;
            vs_reg    <= vs_next;
            pl_reg    <= pl_next;
            eg_reg    <= eg_next;
            drop_reg  <= drop_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            for (int i = 0; i < 3; i++) begin
                ia_reg[i]  <= ia_next[i];
                iap_reg[i] <= iap_next[i];
            end
        end
    end

endmodule

// ===== rtl/emdp_out_fifo.sv =====
module emdp_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  emdp_pkg::res_t      res,
    output logic                room2,
    output logic                m_valid,
    input  logic                m_ready,
    output emdp_pkg::out_item_t m_item
);
    import emdp_pkg::*;

    out_item_t  mem_reg [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] nwr;
    logic       pop;

    assign nwr     = push ? res.count : 2'd0;
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_item  = mem_reg[rd_reg];
    assign room2   = (cnt_reg <= 3'd2);

    always_comb begin
        wr_next  = wr_reg + nwr;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, nwr} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (nwr != 2'd0) mem_reg[wr_reg] <= res.r0;
        if (nwr == 2'd2) mem_reg[wr_reg + 2'd1] <= res.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/energy_meter_datagram_parser_core.sv =====
// Channel | Ports                    | Word
// --------+--------------------------+-------------------------------------
// input   | s_valid/s_ready/s_item   | one datagram byte plus last flag
// result  | m_valid/m_ready/m_item   | measurement or end-of-packet status
// config  | cfg_we/cfg_index/cfg_data| serial filter enable / value
//
// One byte per cycle sustained while the result queue has room: a byte is held
// in the input register, is parsed from there and its results (zero, one or
// two words) land in a four-word result queue. The input register advances
// only while the queue has room for two words; only the queue drain sets stalls.
// Reset is synchronous, active low, and clears the parser, the input register
// and the result queue.
module energy_meter_datagram_parser_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  emdp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output emdp_pkg::out_item_t m_item,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import emdp_pkg::*;

    logic     in_vld_reg;
    in_item_t in_item_reg;
    logic     filt_en_reg;
    logic [31:0] filt_val_reg;
    logic     room2, fire;
    res_t     res;

    // parse the held byte whenever the queue can absorb its worst case
    assign fire    = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // hold the payload until it is parsed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_item_reg <= s_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_en_reg  <= 1'b0;
            filt_val_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FILTER_EN:  filt_en_reg  <= cfg_data[0];
                REG_FILTER_VAL: filt_val_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    emdp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (in_item_reg),
        .filt_en  (filt_en_reg),
        .filt_val (filt_val_reg),
        .res      (res)
    );

    emdp_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .res     (res),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ===== bench/tb_energy_meter_datagram_parser_core.sv =====
`timescale 1ns/1ps
module tb_energy_meter_datagram_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import emdp_pkg::*;

    localparam int WATCHDOG_CYCLES   = 20000;
    localparam int LONG_STALL_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_FILTER_EN;
    logic [31:0] cfg_data = '0;

    energy_meter_datagram_parser_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: filter registers and parser copy.
    logic        flt_en;
    logic [31:0] flt_val;
    phase_t      p_phase;
    int unsigned p_bytes;
    logic [15:0] p_grp_left;
    int unsigned p_field;
    logic [23:0] p_rec_hdr;
    logic [63:0] p_shift;
    logic [31:0] p_imp_act [3];
    logic [31:0] p_imp_app [3];
    logic [1:0]  p_status;
    int unsigned p_pay_left;
    bit          p_empty_grp;

    in_item_t  byte_queue[$];
    out_item_t meter_results[$];
    int        errors = 0;
    bit        hold_driver = 1'b0;
    int        long_req = 0;
    bit        stim_done = 1'b0;

    function automatic out_item_t make_meas(logic [2:0] q, int ph, logic [43:0] v);
        out_item_t r;
        r.record_kind = KIND_MEAS;
        r.quantity = q;
        r.phase = ph[1:0];
        r.value = v;
        r.packet_status = ST_OK;
        return r;
    endfunction

    function automatic void close_record();
        p_field = 0;
        p_shift = '0;
        p_phase = (p_grp_left == 0) ? PH_GHDR : PH_RHDR;
    endfunction

    function automatic void eat_group();
        if (p_grp_left != 0) p_grp_left--;
    endfunction

    // Decode a finished record into at most one measurement.
    function automatic void decode_record();
        int unsigned idx, typ, ph, sub;
        logic [31:0] raw;
        logic [63:0] wh;
        logic signed [43:0] net;
        idx = p_rec_hdr[15:8];
        typ = p_rec_hdr[7:0];
        ph = idx / 20;
        sub = idx % 20;
        raw = p_shift[31:0];
        if (ph < 1 || ph > 3) return;
        ph = ph - 1;
        if (typ == TYPE_ENERGY) begin
            wh = p_shift / 64'd3600000;
            if (sub == 1) meter_results.push_back(make_meas(Q_ENERGY_IN, ph, wh[43:0]));
            else if (sub == 2) meter_results.push_back(make_meas(Q_ENERGY_OUT, ph, wh[43:0]));
            return;
        end
        if (typ != TYPE_POWER) return;
        case (sub)
            1: p_imp_act[ph] = raw;
            2: begin
                net = $signed({12'd0, p_imp_act[ph]}) - $signed({12'd0, raw});
                meter_results.push_back(make_meas(Q_NET_POWER, ph, net));
            end
            9: p_imp_app[ph] = raw;
            10: begin
                net = $signed({12'd0, p_imp_app[ph]}) - $signed({12'd0, raw});
                meter_results.push_back(make_meas(Q_NET_APPAR, ph, net));
            end
            11: meter_results.push_back(make_meas(Q_CURRENT, ph, {12'd0, raw}));
            12: meter_results.push_back(make_meas(Q_VOLTAGE, ph, {12'd0, raw}));
            13: meter_results.push_back(make_meas(Q_PF, ph, {12'd0, raw}));
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [7:0] magic [3];
        int unsigned chan, typ, len, tag;
        magic[0] = 8'h53; magic[1] = 8'h4D; magic[2] = 8'h41;
        case (p_phase)
            PH_HDR: begin
                if (p_field < 3 && b != magic[p_field]) begin
                    p_phase = PH_DONE;
                    p_status = ST_BAD_HDR;
                end else if (p_field >= 3) begin
                    p_field = 0;
                    p_shift = '0;
                    p_phase = PH_GHDR;
                end else p_field++;
            end
            PH_GHDR: begin
                p_shift = {p_shift[55:0], b};
                p_field++;
                if (p_field >= 4) begin
                    len = p_shift[31:16];
                    tag = p_shift[15:0];
                    p_field = 0;
                    p_shift = '0;
                    p_grp_left = len[15:0];
                    if (len == LEN_END) begin
                        p_phase = PH_DONE;
                        p_status = ST_TERM;
                    end else if (tag == TAG_DATA) begin
                        p_empty_grp = (len == 0);
                        p_phase = PH_DPRE;
                    end else if (len == 0) p_phase = PH_DONE;
                    else p_phase = PH_GSKIP;
                end
            end
            PH_GSKIP: begin
                eat_group();
                if (p_grp_left == 0) p_phase = PH_GHDR;
            end
            PH_DPRE: begin
                eat_group();
                p_shift = {p_shift[55:0], b};
                if (p_field == 7 && flt_en && p_shift[31:0] != flt_val) begin
                    p_phase = PH_DONE;
                    p_status = ST_MISMATCH;
                end else begin
                    p_field++;
                    if (p_field >= 12) begin
                        if (p_empty_grp) p_phase = PH_DONE;
                        else close_record();
                    end
                end
            end
            PH_RHDR: begin
                eat_group();
                if (p_field < 3) p_rec_hdr = {p_rec_hdr[15:0], b};
                p_field++;
                if (p_field >= 4) begin
                    chan = p_rec_hdr[23:16];
                    typ = p_rec_hdr[7:0];
                    if (typ == TYPE_ENERGY || typ == TYPE_POWER) len = typ;
                    else if (chan == CHAN_SPECIAL) len = 4;
                    else len = typ;
                    p_field = 0;
                    p_shift = '0;
                    if (len == 0) close_record();
                    else begin
                        p_pay_left = len;
                        p_phase = PH_RDATA;
                    end
                end
            end
            PH_RDATA: begin
                eat_group();
                p_shift = {p_shift[55:0], b};
                p_pay_left--;
                if (p_pay_left == 0) begin
                    decode_record();
                    close_record();
                end
            end
            default: ;
        endcase
    endfunction

    // Work out the results of one accepted word.
    function automatic void predict_word(in_item_t w);
        out_item_t st;
        if (p_bytes == 0) begin
            for (int i = 0; i < 3; i++) begin
                p_imp_act[i] = '0;
                p_imp_app[i] = '0;
            end
            p_status = ST_OK;
            p_phase = PH_HDR;
            p_field = 0;
            p_shift = '0;
            p_grp_left = '0;
            p_rec_hdr = '0;
            p_pay_left = 0;
            p_empty_grp = 1'b0;
        end
        if (p_bytes < MAX_PACKET_BYTES) begin
            parse_byte(w.data_byte);
            p_bytes++;
        end
        if (w.last_byte) begin
            if (p_phase == PH_HDR) p_status = ST_BAD_HDR;
            st = '0;
            st.record_kind = KIND_STATUS;
            st.packet_status = p_status;
            meter_results.push_back(st);
            p_bytes = 0;
            p_phase = PH_HDR;
            p_field = 0;
            p_shift = '0;
        end
    endfunction

    // Datagram builders: append bytes to a scratch list, then flush.
    logic [7:0] dg[$];

    function automatic void put16(int unsigned v);
        dg.push_back(v[15:8]); dg.push_back(v[7:0]);
    endfunction

    function automatic void put_n(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) dg.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_dg(int cut);
        int n;
        in_item_t w;
        n = (cut > 0 && cut < dg.size()) ? cut : dg.size();
        for (int i = 0; i < n; i++) begin
            w.data_byte = dg[i];
            w.last_byte = (i == n - 1);
            byte_queue.push_back(w);
        end
        dg.delete();
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Build a well-formed datagram with random records.
    function automatic void build_meter_dg(logic [31:0] serial, int nrec);
        int lenpos, start, typ, idx, chan;
        int unsigned glen;
        dg.push_back(8'h53); dg.push_back(8'h4D); dg.push_back(8'h41);
        dg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) begin
            put16(4); put16(16'h02A0); put_n(rnd64(), 4);
        end
        lenpos = dg.size();
        put16(0); put16(TAG_DATA);
        start = dg.size();
        put16($urandom_range(0, 65535));
        put16($urandom_range(0, 65535));
        put_n({32'd0, serial}, 4);
        put_n(rnd64(), 4);
        for (int r = 0; r < nrec; r++) begin
            case ($urandom_range(0, 9))
                0, 1: begin typ = TYPE_ENERGY; idx = 20 * $urandom_range(1, 3) + $urandom_range(1, 2); end
                2: begin typ = $urandom_range(0, 12); idx = $urandom_range(0, 255); end
                default: begin
                    typ = TYPE_POWER;
                    idx = 20 * $urandom_range(1, 3)
                        + (($urandom_range(0, 5) == 0) ? $urandom_range(0, 19) : $urandom_range(9, 13));
                    if ($urandom_range(0, 3) == 0) idx = 20 * $urandom_range(1, 3) + $urandom_range(1, 2);
                end
            endcase
            chan = ($urandom_range(0, 7) == 0) ? CHAN_SPECIAL : $urandom_range(0, 255);
            dg.push_back(8'(chan)); dg.push_back(8'(idx)); dg.push_back(8'(typ));
            dg.push_back(8'($urandom_range(0, 255)));
            if (typ == TYPE_ENERGY || typ == TYPE_POWER || chan != CHAN_SPECIAL)
                put_n(($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rnd64(), typ);
            else put_n(rnd64(), 4);
        end
        glen = dg.size() - start;
        dg[lenpos] = glen[15:8];
        dg[lenpos + 1] = glen[7:0];
        if ($urandom_range(0, 1)) begin put16(0); put16(0); end
        else begin put16(16'hFFFF); put16($urandom_range(0, 65535)); end
    endfunction

    // Driver: bursts with random gaps; keep valid high without re-raising.
    int gap_left = 0, burst_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the word
        end else begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (!hold_driver && byte_queue.size() > 0) begin
                s_item <= byte_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
                end else burst_left <= burst_left - 1;
            end else s_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, plus one long hold-off counted here.
    int stall_phase = 0;
    int long_left = 0;
    int long_ack = 0;
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else begin
            stall_phase <= stall_phase + 1;
            if (long_req != long_ack) begin
                long_ack <= long_req;
                long_left <= LONG_STALL_CYCLES;
                m_ready <= 1'b0;
            end else if (long_left > 0) begin
                long_left <= long_left - 1;
                m_ready <= 1'b0;
            end else if (stall_phase[9]) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: predict on accepted bytes, check accepted results.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_word(s_item);
            if (m_valid && m_ready) begin
                if (meter_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_item);
                    errors++;
                end else begin
                    out_item_t e;
                    e = meter_results.pop_front();
                    if (e.record_kind !== m_item.record_kind || e.quantity !== m_item.quantity
                        || e.phase !== m_item.phase || e.value !== m_item.value
                        || e.packet_status !== m_item.packet_status) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, m_item);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("tb_energy_meter_datagram_parser_core: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FILTER_EN) flt_en = val[0];
        else flt_val = val;
    endtask

    // Let everything queued drain and the block settle.
    task automatic drain();
        while (byte_queue.size() > 0 || s_valid || meter_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] ser;
        flt_en = 1'b0; flt_val = '0; p_bytes = 0; p_status = ST_OK; p_phase = PH_HDR;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: bad header, truncated header, lone byte, terminator, filter.
        dg.push_back(8'h53); dg.push_back(8'h00); dg.push_back(8'h41); push_dg(0);
        dg.push_back(8'h53); dg.push_back(8'h4D); push_dg(0);
        dg.push_back(8'hFF); push_dg(0);
        build_meter_dg(32'hFFFF_FFFF, 2); push_dg(0);
        build_meter_dg(32'h0, 1); push_dg(20);
        drain();
        write_reg(REG_FILTER_VAL, 32'hFFFF_FFFF);
        write_reg(REG_FILTER_EN, 32'd1);
        build_meter_dg(32'hFFFF_FFFF, 1); push_dg(0);
        build_meter_dg(32'h1234_5678, 1); push_dg(0);
        drain();
        write_reg(REG_FILTER_VAL, 32'h0);
        build_meter_dg(32'h0, 1); push_dg(0);
        drain();

        // Long receiver hold-off while the sender keeps offering words.
        long_req = long_req + 1;
        build_meter_dg($urandom(), 6); push_dg(0);
        build_meter_dg($urandom(), 6); push_dg(0);
        wait (long_ack == long_req && long_left == 0);
        drain();

        // Random datagrams over several filter settings.
        for (int phs = 0; phs < 4; phs++) begin
            ser = $urandom();
            write_reg(REG_FILTER_EN, {31'd0, phs[0]});
            write_reg(REG_FILTER_VAL, (phs == 3) ? 32'hFFFF_FFFF : ser);
            for (int d = 0; d < 3; d++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        for (int i = $urandom_range(1, 12); i > 0; i--)
                            dg.push_back(8'($urandom_range(0, 255)));
                        push_dg(0);
                    end
                    1: begin build_meter_dg(ser, $urandom_range(1, 5)); push_dg($urandom_range(5, 60)); end
                    2: begin build_meter_dg($urandom(), $urandom_range(1, 4)); push_dg(0); end
                    default: begin build_meter_dg(ser, $urandom_range(1, 6)); push_dg(0); end
                endcase
            end
            // Pause the sender, once every word is out, until every expected result has come.
            while (byte_queue.size() > 0) @(posedge aclk);
            hold_driver = 1'b1;
            drain();
            hold_driver = 1'b0;
        end

        stim_done = 1'b1;
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("tb_energy_meter_datagram_parser_core: clean");
        else $display("tb_energy_meter_datagram_parser_core: errors");
        $finish;
    end
endmodule
